// File: design/rpbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbd_pkg: shared types and constants
// Configuration record, result record, register map and request codes for
// the RGB PWM button dimmer.
// ----------------------------------------------------------------------------
package rpbd_pkg;

  localparam int NUM_CH  = 3;
  localparam int NUM_BTN = 6;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_START_GREEN   = 3'd0,
    REG_START_RED     = 3'd1,
    REG_START_BLUE    = 3'd2,
    REG_SAMPLE_PERIOD = 3'd3,
    REG_FRAME_TICKS   = 3'd4,
    REG_WINDOW_TICKS  = 3'd5,
    REG_STEP_SIZE     = 3'd6
  } reg_idx_t;

  localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd2000;
  localparam logic [7:0]  FRAME_TICKS_RST   = 8'd120;
  localparam logic [7:0]  WINDOW_TICKS_RST  = 8'd10;
  localparam logic [7:0]  STEP_SIZE_RST     = 8'd10;

  localparam logic [1:0] PRESS_MAX = 2'd2;
  localparam logic [1:0] PRESS_ONE = 2'd1;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_SAVE  = 2'd1,
    REQ_CLEAR = 2'd2
  } store_req_t;

  typedef struct packed {
    logic [7:0]  start_green;
    logic [7:0]  start_red;
    logic [7:0]  start_blue;
    logic [15:0] sample_period;
    logic [7:0]  frame_ticks;
    logic [7:0]  window_ticks;
    logic [7:0]  step_size;
  } cfg_t;

  typedef struct packed {
    logic       led_green;
    logic       led_red;
    logic       led_blue;
    logic [1:0] store_request;
    logic [7:0] save_green;
    logic [7:0] save_red;
    logic [7:0] save_blue;
  } result_t;

endpackage

// File: design/rpbd_tick_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbd_tick_if: input tick channel
// Valid/ready channel carrying button levels and the timer overflow flag.
// ----------------------------------------------------------------------------
interface rpbd_tick_if;
  logic       valid;
  logic       ready;
  logic [5:0] buttons;
  logic       timer_overflow;

  modport source (output valid, output buttons, output timer_overflow, input ready);
  modport sink (input valid, input buttons, input timer_overflow, output ready);
endinterface

// File: design/rpbd_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbd_result_if: result channel
// Valid/ready channel carrying LED levels and the store request.
// ----------------------------------------------------------------------------
interface rpbd_result_if;
  logic       valid;
  logic       ready;
  logic       led_green;
  logic       led_red;
  logic       led_blue;
  logic [1:0] store_request;
  logic [7:0] save_green;
  logic [7:0] save_red;
  logic [7:0] save_blue;

  modport source (
    output valid, output led_green, output led_red, output led_blue,
    output store_request, output save_green, output save_red, output save_blue,
    input ready
  );
  modport sink (
    input valid, input led_green, input led_red, input led_blue,
    input store_request, input save_green, input save_red, input save_blue,
    output ready
  );
endinterface

// File: design/rpbd_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbd_regs: configuration register file
// APB-style write/read port for the seven dimmer control registers.
// ----------------------------------------------------------------------------
module rpbd_regs
  import rpbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_green   <= '0;
      cfg.start_red     <= '0;
      cfg.start_blue    <= '0;
      cfg.sample_period <= SAMPLE_PERIOD_RST;
      cfg.frame_ticks   <= FRAME_TICKS_RST;
      cfg.window_ticks  <= WINDOW_TICKS_RST;
      cfg.step_size     <= STEP_SIZE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_START_GREEN:   cfg.start_green   <= pwdata[7:0];
        REG_START_RED:     cfg.start_red     <= pwdata[7:0];
        REG_START_BLUE:    cfg.start_blue    <= pwdata[7:0];
        REG_SAMPLE_PERIOD: cfg.sample_period <= pwdata[15:0];
        REG_FRAME_TICKS:   cfg.frame_ticks   <= pwdata[7:0];
        REG_WINDOW_TICKS:  cfg.window_ticks  <= pwdata[7:0];
        REG_STEP_SIZE:     cfg.step_size     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START_GREEN:   prdata = {24'd0, cfg.start_green};
      REG_START_RED:     prdata = {24'd0, cfg.start_red};
      REG_START_BLUE:    prdata = {24'd0, cfg.start_blue};
      REG_SAMPLE_PERIOD: prdata = {16'd0, cfg.sample_period};
      REG_FRAME_TICKS:   prdata = {24'd0, cfg.frame_ticks};
      REG_WINDOW_TICKS:  prdata = {24'd0, cfg.window_ticks};
      REG_STEP_SIZE:     prdata = {24'd0, cfg.step_size};
      default:           prdata = '0;
    endcase
  end

endmodule

// File: design/rpbd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbd_core: dimmer state and tick logic
// Holds PWM phase, dividers, brightness, enables and press counters; forms
// the result of the current tick and advances the state on each step.
// ----------------------------------------------------------------------------
module rpbd_core
  import rpbd_pkg::*;
#(
  parameter int PWM_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic [5:0] buttons,
  input  logic       timer_overflow,
  output result_t    res
);

  localparam int CMP_W = (PWM_BITS > 8) ? PWM_BITS : 8;

  logic                start_loaded;
  logic [PWM_BITS-1:0] pwm_phase;
  logic [15:0]         sample_count;
  logic [7:0]          overflow_count;
  logic [7:0]          brightness [NUM_CH];
  logic [NUM_CH-1:0]   chan_en;
  logic [NUM_BTN-1:0]  was_down;
  logic [1:0]          press [NUM_BTN];
  logic                frame_done;

  logic [15:0]         sample_count_next;
  logic [7:0]          overflow_count_next;
  logic [7:0]          brightness_next [NUM_CH];
  logic [NUM_CH-1:0]   chan_en_next;
  logic [NUM_BTN-1:0]  was_down_next;
  logic [1:0]          press_next [NUM_BTN];
  logic                frame_done_next;

  logic [7:0]          bri_cur [NUM_CH];
  logic [1:0]          press_s [NUM_BTN];
  logic [NUM_CH-1:0]   led;
  logic [16:0]         sample_inc;
  logic                do_sample;
  logic [8:0]          ovf_inc;
  logic                in_window;
  logic                process;
  logic                all_plus;
  logic                all_minus;

  always_comb begin
    // start values show through until the first tick latches them
    bri_cur[0] = start_loaded ? brightness[0] : cfg.start_green;
    bri_cur[1] = start_loaded ? brightness[1] : cfg.start_red;
    bri_cur[2] = start_loaded ? brightness[2] : cfg.start_blue;
    for (int c = 0; c < NUM_CH; c++) begin
      led[c] = chan_en[c] &&
               (CMP_W'(pwm_phase) < CMP_W'(bri_cur[c]));
    end

    sample_inc        = {1'b0, sample_count} + 17'd1;
    do_sample         = sample_inc >= {1'b0, cfg.sample_period};
    sample_count_next = do_sample ? 16'd0 : sample_inc[15:0];

    for (int i = 0; i < NUM_BTN; i++) begin
      press_s[i]       = press[i];
      was_down_next[i] = was_down[i];
      if (do_sample) begin
        if (buttons[i] && !was_down[i]) begin
          if (press[i] < PRESS_MAX) press_s[i] = press[i] + 2'd1;
          was_down_next[i] = 1'b1;
        end else if (!buttons[i]) begin
          was_down_next[i] = 1'b0;
        end
      end
    end

    ovf_inc = {1'b0, overflow_count} + 9'd1;
    if (timer_overflow) begin
      overflow_count_next = (ovf_inc >= {1'b0, cfg.frame_ticks}) ? 8'd0 : ovf_inc[7:0];
    end else begin
      overflow_count_next = overflow_count;
    end

    in_window       = overflow_count_next < cfg.window_ticks;
    process         = in_window && !frame_done;
    frame_done_next = in_window;

    all_plus  = (press_s[0] != 2'd0) && (press_s[1] != 2'd0) && (press_s[2] != 2'd0);
    all_minus = (press_s[3] != 2'd0) && (press_s[4] != 2'd0) && (press_s[5] != 2'd0);

    res.led_green     = led[0];
    res.led_red       = led[1];
    res.led_blue      = led[2];
    res.store_request = REQ_NONE;
    res.save_green    = '0;
    res.save_red      = '0;
    res.save_blue     = '0;
    if (process && all_plus) begin
      res.store_request = REQ_CLEAR;
    end else if (process && all_minus) begin
      res.store_request = REQ_SAVE;
      res.save_green    = bri_cur[0];
      res.save_red      = bri_cur[1];
      res.save_blue     = bri_cur[2];
    end

    chan_en_next = chan_en;
    for (int c = 0; c < NUM_CH; c++) begin
      brightness_next[c] = bri_cur[c];
      if (process) begin
        // plus applies first, so a double minus wins the enable
        if (press_s[c] == PRESS_ONE) begin
          brightness_next[c] = brightness_next[c] + cfg.step_size;
        end else if (press_s[c] >= PRESS_MAX) begin
          chan_en_next[c] = 1'b1;
        end
        if (press_s[c+NUM_CH] == PRESS_ONE) begin
          brightness_next[c] = brightness_next[c] - cfg.step_size;
        end else if (press_s[c+NUM_CH] >= PRESS_MAX) begin
          chan_en_next[c] = 1'b0;
        end
      end
    end
    for (int i = 0; i < NUM_BTN; i++) begin
      press_next[i] = process ? 2'd0 : press_s[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_loaded   <= 1'b0;
      pwm_phase      <= '0;
      sample_count   <= '0;
      overflow_count <= '0;
      chan_en        <= '1;
      was_down       <= '0;
      frame_done     <= 1'b0;
      for (int i = 0; i < NUM_BTN; i++) press[i] <= '0;
    end else if (step) begin
      start_loaded   <= 1'b1;
      pwm_phase      <= pwm_phase + PWM_BITS'(1);
      sample_count   <= sample_count_next;
      overflow_count <= overflow_count_next;
      chan_en        <= chan_en_next;
      was_down       <= was_down_next;
      frame_done     <= frame_done_next;
      for (int i = 0; i < NUM_BTN; i++) press[i] <= press_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int c = 0; c < NUM_CH; c++) brightness[c] <= brightness_next[c];
    end
  end

endmodule

// File: design/rgb_pwm_button_dimmer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_pwm_button_dimmer: three-channel PWM LED dimmer with button control
//
//   channel   dir  handshake      payload
//   ticks     in   valid/ready    buttons[5:0], timer_overflow
//   results   out  valid/ready    led_green/red/blue, store_request, save_*
//   apb       in   psel/penable   paddr[4:0], pwdata/prdata[31:0]
//
// One tick per cycle sustained while the result is not stalled; a tick passes
// through the input register, then the tick logic into the result register.
// Synchronous reset clears all control state; brightness is taken from the
// start registers on the first tick. A stalled result holds; the input
// register takes a tick when it is empty, or when its own tick moves on
// because the result register is empty or drained in the same cycle.
// ----------------------------------------------------------------------------
module rgb_pwm_button_dimmer
  import rpbd_pkg::*;
#(
  parameter int PWM_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  rpbd_tick_if.sink         ticks,
  rpbd_result_if.source     results,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  result_t    res;
  result_t    out_res;
  logic       out_valid;
  logic       s1_valid;
  logic [5:0] s1_buttons;
  logic       s1_ovf;
  logic       advance;

  rpbd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rpbd_core #(
    .PWM_BITS (PWM_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .step           (advance),
    .buttons        (s1_buttons),
    .timer_overflow (s1_ovf),
    .res            (res)
  );

  assign advance     = s1_valid && (!out_valid || results.ready);
  assign ticks.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ticks.valid && ticks.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ticks.valid && ticks.ready) begin
      s1_buttons <= ticks.buttons;
      s1_ovf     <= ticks.timer_overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= res;
  end

  assign results.valid         = out_valid;
  assign results.led_green     = out_res.led_green;
  assign results.led_red       = out_res.led_red;
  assign results.led_blue      = out_res.led_blue;
  assign results.store_request = out_res.store_request;
  assign results.save_green    = out_res.save_green;
  assign results.save_red      = out_res.save_red;
  assign results.save_blue     = out_res.save_blue;

endmodule
